// File: hdl/cpbd_pkg.sv
// ============================================================================
// cpbd_pkg
// Types and constants shared by the peak box decoder: the request and
// response items, the register indexes and the register reset values.
// ============================================================================
package cpbd_pkg;

   localparam int COORD_BITS = 12;
   localparam int CELL_BITS  = 10;
   localparam int SCORE_BITS = 16;
   localparam int DIM_BITS   = 13;
   localparam int CSR_BITS   = 24;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SCORE_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NET_WIDTH       = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NET_HEIGHT      = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INVERSE_SCALE   = 3'd5;

   localparam logic [SCORE_BITS-1:0] RST_SCORE_THRESHOLD = 16'd26214;
   localparam logic [DIM_BITS-1:0]   RST_NET_WIDTH       = 13'd1088;
   localparam logic [DIM_BITS-1:0]   RST_NET_HEIGHT      = 13'd608;
   localparam logic [DIM_BITS-1:0]   RST_IMAGE_WIDTH     = 13'd1920;
   localparam logic [DIM_BITS-1:0]   RST_IMAGE_HEIGHT    = 13'd1080;
   localparam logic [CSR_BITS-1:0]   RST_INVERSE_SCALE   = 24'd115652;

   typedef struct packed {
      logic [SCORE_BITS-1:0] heat_value;
      logic [SCORE_BITS-1:0] pooled_value;
      logic [CELL_BITS-1:0]  cell_x;
      logic [CELL_BITS-1:0]  cell_y;
      logic signed [15:0]    offset_x;
      logic signed [15:0]    offset_y;
      logic signed [15:0]    extent_left;
      logic signed [15:0]    extent_top;
      logic signed [15:0]    extent_right;
      logic signed [15:0]    extent_bottom;
   } cpbd_req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] box_left;
      logic [COORD_BITS-1:0] box_top;
      logic [DIM_BITS-1:0]   box_width;
      logic [DIM_BITS-1:0]   box_height;
      logic [SCORE_BITS-1:0] box_score;
      logic [CELL_BITS-1:0]  source_col;
      logic [CELL_BITS-1:0]  source_row;
   } cpbd_rsp_type;

   typedef struct packed {
      logic [SCORE_BITS-1:0] score;
      logic [CELL_BITS-1:0]  col;
      logic [CELL_BITS-1:0]  row;
   } cpbd_tag_type;

endpackage

// File: hdl/centernet_peak_box_decode_top.sv
// ============================================================================
// centernet_peak_box_decode_top
// A detection is carried through the stage 1 to stage 6 registers to rsp.
// Throughput: one item per cycle unless rsp_ready stalls it, through six register
// stages; the edge multipliers (one per box edge) sit in stage 3.
// Cells that are not detections, or whose box clips to nothing, leave no item.
// Reset clears all valid bits and loads the register defaults.
// ============================================================================
module centernet_peak_box_decode_top #(
   parameter int STRIDE = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  cpbd_pkg::cpbd_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output cpbd_pkg::cpbd_rsp_type             rsp_data,
   input  logic                               csr_write_en,
   input  logic [cpbd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [cpbd_pkg::CSR_BITS-1:0]      csr_wdata
);
   import cpbd_pkg::*;

   localparam int S_BITS = 20;
   localparam int U_BITS = S_BITS + $clog2(STRIDE) + 2;
   localparam int P_BITS = U_BITS + 25;
   localparam int V_BITS = P_BITS + 1;
   localparam int E_BITS = V_BITS - 24;
   localparam logic [V_BITS-1:0] HALF_Q24 = V_BITS'(1) << 23;
   localparam logic [DIM_BITS-1:0] COORD_LIM = DIM_BITS'(1) << COORD_BITS;

   // Configuration registers.
   logic [SCORE_BITS-1:0] thresh_ff;
   logic [DIM_BITS-1:0]   net_w_ff, net_h_ff, img_w_ff, img_h_ff;
   logic [CSR_BITS-1:0]   inv_ff;
   logic [DIM_BITS-1:0]   wlim, hlim;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= RST_SCORE_THRESHOLD;
         net_w_ff  <= RST_NET_WIDTH;
         net_h_ff  <= RST_NET_HEIGHT;
         img_w_ff  <= RST_IMAGE_WIDTH;
         img_h_ff  <= RST_IMAGE_HEIGHT;
         inv_ff    <= RST_INVERSE_SCALE;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SCORE_THRESHOLD: thresh_ff <= csr_wdata[SCORE_BITS-1:0];
            CSR_NET_WIDTH:       net_w_ff  <= csr_wdata[DIM_BITS-1:0];
            CSR_NET_HEIGHT:      net_h_ff  <= csr_wdata[DIM_BITS-1:0];
            CSR_IMAGE_WIDTH:     img_w_ff  <= csr_wdata[DIM_BITS-1:0];
            CSR_IMAGE_HEIGHT:    img_h_ff  <= csr_wdata[DIM_BITS-1:0];
            CSR_INVERSE_SCALE:   inv_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign wlim = (img_w_ff > COORD_LIM) ? COORD_LIM : img_w_ff;
   assign hlim = (img_h_ff > COORD_LIM) ? COORD_LIM : img_h_ff;

   // Pipeline control: a stage loads when it is empty or its successor loads.
   logic [6:1] vld_ff;
   logic [6:1] adv;

   assign adv[6] = ~vld_ff[6] | rsp_ready;
   assign adv[5] = ~vld_ff[5] | adv[6];
   assign adv[4] = ~vld_ff[4] | adv[5];
   assign adv[3] = ~vld_ff[3] | adv[4];
   assign adv[2] = ~vld_ff[2] | adv[3];
   assign adv[1] = ~vld_ff[1] | adv[2];
   assign req_ready = adv[1];

   // Lanes: 0 left, 1 top, 2 right, 3 bottom.
   cpbd_tag_type tag_ff [1:5];
   logic [S_BITS-1:0] s_ff [4];
   logic [S_BITS-1:0] s_in [4];
   logic [U_BITS-1:0] u_ff [4];
   logic [U_BITS-1:0] u_in [4];
   logic [P_BITS-1:0] p_ff [4];
   logic [P_BITS-1:0] p_in [4];
   logic signed [E_BITS-1:0] e_ff [4];
   logic signed [E_BITS-1:0] e_in [4];
   logic signed [E_BITS-1:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic signed [E_BITS-1:0] x0_in, x1_in, y0_in, y1_in;
   logic signed [E_BITS-1:0] xlo, xhi, ylo, yhi, wlim_s, hlim_s;
   logic [S_BITS-1:0] base_x, base_y;
   logic [V_BITS-1:0] v_sum;
   logic detect, keep;
   logic [E_BITS-1:0] w_diff, h_diff;
   cpbd_rsp_type rsp_ff, rsp_in;

   // Stage 1: peak test and Q.8 cell positions of the box edges.
   always_comb begin
      detect = (req_data.heat_value == req_data.pooled_value)
             && (req_data.pooled_value > thresh_ff);
      base_x = {{(S_BITS-18){1'b0}}, req_data.cell_x, 8'h00}
             + {{(S_BITS-16){req_data.offset_x[15]}}, req_data.offset_x};
      base_y = {{(S_BITS-18){1'b0}}, req_data.cell_y, 8'h00}
             + {{(S_BITS-16){req_data.offset_y[15]}}, req_data.offset_y};
      s_in[0] = base_x - {{(S_BITS-16){req_data.extent_left[15]}}, req_data.extent_left};
      s_in[1] = base_y - {{(S_BITS-16){req_data.extent_top[15]}}, req_data.extent_top};
      s_in[2] = base_x + {{(S_BITS-16){req_data.extent_right[15]}}, req_data.extent_right};
      s_in[3] = base_y + {{(S_BITS-16){req_data.extent_bottom[15]}}, req_data.extent_bottom};
   end

   // Stage 2: scale by the stride and center on the network frame.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         u_in[i] = {{(U_BITS-S_BITS){s_ff[i][S_BITS-1]}}, s_ff[i]} * U_BITS'(STRIDE)
                 - {{(U_BITS-20){1'b0}}, ((i % 2) == 0) ? net_w_ff : net_h_ff, 7'h00};
      end
   end

   // Stage 3: multiply by the reciprocal scale.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         p_in[i] = P_BITS'($signed(u_ff[i]) * $signed({1'b0, inv_ff}));
      end
   end

   // Stage 4: shift to the image center and round to a pixel.
   always_comb begin
      v_sum = '0;
      for (int i = 0; i < 4; i++) begin
         v_sum = {p_ff[i][P_BITS-1], p_ff[i]}
               + {{(V_BITS-36){1'b0}}, ((i % 2) == 0) ? img_w_ff : img_h_ff, 23'h0}
               + HALF_Q24;
         e_in[i] = $signed(v_sum[V_BITS-1:24]) + ((i >= 2) ? E_BITS'(1) : E_BITS'(0));
      end
   end

   // Stage 5: order the corners and clip to the image.
   always_comb begin
      wlim_s = $signed({{(E_BITS-DIM_BITS){1'b0}}, wlim});
      hlim_s = $signed({{(E_BITS-DIM_BITS){1'b0}}, hlim});
      xlo = (e_ff[0] < e_ff[2]) ? e_ff[0] : e_ff[2];
      xhi = (e_ff[0] < e_ff[2]) ? e_ff[2] : e_ff[0];
      ylo = (e_ff[1] < e_ff[3]) ? e_ff[1] : e_ff[3];
      yhi = (e_ff[1] < e_ff[3]) ? e_ff[3] : e_ff[1];
      x0_in = (xlo < 0) ? '0 : xlo;
      y0_in = (ylo < 0) ? '0 : ylo;
      x1_in = (xhi > wlim_s) ? wlim_s : xhi;
      y1_in = (yhi > hlim_s) ? hlim_s : yhi;
   end

   // Stage 6: drop empty boxes and form the result item.
   always_comb begin
      keep   = (x1_ff > x0_ff) && (y1_ff > y0_ff);
      w_diff = x1_ff - x0_ff;
      h_diff = y1_ff - y0_ff;
      rsp_in.box_left   = x0_ff[COORD_BITS-1:0];
      rsp_in.box_top    = y0_ff[COORD_BITS-1:0];
      rsp_in.box_width  = w_diff[DIM_BITS-1:0];
      rsp_in.box_height = h_diff[DIM_BITS-1:0];
      rsp_in.box_score  = tag_ff[5].score;
      rsp_in.source_col = tag_ff[5].col;
      rsp_in.source_row = tag_ff[5].row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[1]) vld_ff[1] <= req_valid & detect;
         if (adv[2]) vld_ff[2] <= vld_ff[1];
         if (adv[3]) vld_ff[3] <= vld_ff[2];
         if (adv[4]) vld_ff[4] <= vld_ff[3];
         if (adv[5]) vld_ff[5] <= vld_ff[4];
         if (adv[6]) vld_ff[6] <= vld_ff[5] & keep;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s_ff         <= s_in;
         tag_ff[1]    <= '{score: req_data.pooled_value, col: req_data.cell_x,
                           row: req_data.cell_y};
      end
      if (adv[2]) begin
         u_ff      <= u_in;
         tag_ff[2] <= tag_ff[1];
      end
      if (adv[3]) begin
         p_ff      <= p_in;
         tag_ff[3] <= tag_ff[2];
      end
      if (adv[4]) begin
         e_ff      <= e_in;
         tag_ff[4] <= tag_ff[3];
      end
      if (adv[5]) begin
         x0_ff     <= x0_in;
         x1_ff     <= x1_in;
         y0_ff     <= y0_in;
         y1_ff     <= y1_in;
         tag_ff[5] <= tag_ff[4];
      end
      if (adv[6]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[6];
   assign rsp_data  = rsp_ff;

   a_size_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.box_width != '0) && (rsp_data.box_height != '0))
      else $error("result item with an empty box");

   a_inside_x : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.box_left} + rsp_data.box_width) <= wlim)
      else $error("box extends past the right clip limit");

   a_inside_y : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.box_top} + rsp_data.box_height) <= hlim)
      else $error("box extends past the bottom clip limit");

   a_ready_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> vld_ff[1] && vld_ff[6] && !rsp_ready)
      else $error("input held off while the pipeline has room");

endmodule
